@@ sv/rscpu_pkg.sv @@
`timescale 1ns / 1ps

package rscpu_pkg;

    localparam int DataDepthDef = 1024;
    localparam int NumRegsDef   = 16;
    localparam int WordBitsDef  = 32;
    localparam int PcBits       = 20;
    localparam int SizeBits     = 11;
    localparam logic [SizeBits-1:0] SizeReset = 11'd1024;

    typedef enum logic [1:0] {
        MD_EXEC, MD_PRELOAD, MD_SETSP, MD_RSVD
    } t_mode;

    typedef enum logic [3:0] {
        OP_ILL, OP_NOP, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_BRANCH,
        OP_CALL, OP_RET, OP_PUSH, OP_POP, OP_HALT
    } t_op;

    typedef enum logic [2:0] {
        ST_OK, ST_HALT, ST_ILL, ST_UNK, ST_COND, ST_DATA, ST_STACK, ST_IMM
    } t_status;

    typedef enum logic [1:0] {
        CC_UNSET, CC_ZERO, CC_POS, CC_NEG
    } t_cc;

    typedef enum logic [3:0] {
        CD_ALWAYS, CD_EQ, CD_NE, CD_GT, CD_GE, CD_LT, CD_LE
    } t_cond;

    typedef enum logic [1:0] {
        SP_KEEP, SP_LOAD, SP_INC, SP_DEC
    } t_sp_op;

    typedef enum logic [1:0] {
        NPC_PC, NPC_TARGET, NPC_RDATA
    } t_npc_sel;

    typedef enum logic [1:0] {
        ALU_PASS, ALU_ADD, ALU_SUB
    } t_alu;

    typedef struct packed {
        t_status  st;
        logic     wr_mem;
        logic     wr_reg;
        logic     use_rd;
        t_alu     alu;
        t_sp_op   sp_op;
        t_npc_sel npc_sel;
    } t_ctl;

    // returns {bad, taken}
    function automatic logic [1:0] cond_eval(input logic [3:0] c, input t_cc cc);
        logic [1:0] res;
        res = 2'b00;
        case (c)
            CD_ALWAYS: res = 2'b01;
            CD_EQ:     res = {1'b0, cc == CC_ZERO};
            CD_NE:     res = {1'b0, cc != CC_ZERO};
            CD_GT:     res = {1'b0, cc == CC_POS};
            CD_GE:     res = {1'b0, cc == CC_POS || cc == CC_ZERO};
            CD_LT:     res = {1'b0, cc == CC_NEG};
            CD_LE:     res = {1'b0, cc == CC_NEG || cc == CC_ZERO};
            default:   res = 2'b10;
        endcase
        return res;
    endfunction

endpackage

@@ sv/rscpu_in_if.sv @@
`timescale 1ns / 1ps

interface rscpu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [3:0]         opcode;
    logic [3:0]         cond_or_reg;
    logic               immediate_flag;
    logic               indexed_flag;
    logic [3:0]         index_reg;
    logic signed [15:0] offset;
    logic [19:0]        abs_address;
    logic signed [19:0] imm_value;
    logic signed [31:0] load_value;
    logic [19:0]        pc_after_fetch;

    modport source (
        output valid, mode, opcode, cond_or_reg, immediate_flag, indexed_flag,
               index_reg, offset, abs_address, imm_value, load_value, pc_after_fetch,
        input  ready
    );
    modport sink (
        input  valid, mode, opcode, cond_or_reg, immediate_flag, indexed_flag,
               index_reg, offset, abs_address, imm_value, load_value, pc_after_fetch,
        output ready
    );
endinterface

@@ sv/rscpu_out_if.sv @@
`timescale 1ns / 1ps

interface rscpu_out_if;
    logic               valid;
    logic               ready;
    logic [19:0]        next_pc;
    logic [2:0]         status;
    logic [1:0]         cond_code;
    logic signed [31:0] reg_value;
    logic signed [31:0] stack_pointer;

    modport source (
        output valid, next_pc, status, cond_code, reg_value, stack_pointer,
        input  ready
    );
    modport sink (
        input  valid, next_pc, status, cond_code, reg_value, stack_pointer,
        output ready
    );
endinterface

@@ sv/rscpu_ram.sv @@
`timescale 1ns / 1ps

module rscpu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

@@ sv/register_stack_cpu_execute_unit.sv @@
// execute stage of a small load/store teaching machine
// channels: i_in (sink) takes one decoded instruction or a preload / set-sp beat,
// o_res (source) returns exactly one result beat per input beat, in order
// i_cfg_we / i_cfg_wdata write the data size register (addresses at or above it fault)
// a beat accepted passes through stage b (register operands), stage c (data read,
// commit) and the output register; a new beat is taken only while stage b is empty,
// so the next beat may enter while the last one is still in stage c
// the register file sits in two NUM_REGS-entry rams (one per read port) with valid bits,
// the data memory in one ram of DATA_DEPTH words, never cleared
// reset: registers read as zero, stack pointer zero, condition code unset,
// data size 1024; data words hold garbage until written
// a stalled result waits in the output register; the next beat is still taken
// and read ahead, but nothing is committed until the output register frees
// on any error or halt no state changes and next_pc is the fetch pc
`timescale 1ns / 1ps

module register_stack_cpu_execute_unit
    import rscpu_pkg::*;
#(
    parameter int DATA_DEPTH = DataDepthDef,
    parameter int NUM_REGS   = NumRegsDef,
    parameter int WORD_BITS  = WordBitsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SizeBits-1:0] i_cfg_wdata,
    rscpu_in_if.sink            i_in,
    rscpu_out_if.source         o_res
);
    localparam int W        = WORD_BITS;
    localparam int AW       = $clog2(DATA_DEPTH);
    localparam int RIW      = $clog2(NUM_REGS);
    localparam int SZW      = (AW + 1 > SizeBits) ? AW + 1 : SizeBits;
    localparam int CW       = (W > SZW) ? W : SZW;
    localparam int ModSteps = 15 / NUM_REGS;

    function automatic logic [RIW-1:0] reg_sel(input logic [3:0] v);
        logic [4:0] x;
        x = {1'b0, v};
        for (int k = 0; k < ModSteps; k++) begin
            if (x >= 5'(NUM_REGS)) begin
                x = x - 5'(NUM_REGS);
            end
        end
        return RIW'(x);
    endfunction

    function automatic logic in_data(input logic [W-1:0] w, input logic [SZW-1:0] lim);
        return !w[W-1] && (CW'(w) < CW'(lim));
    endfunction

    function automatic t_cc cc_of(input logic [W-1:0] w);
        t_cc c;
        if (w[W-1]) begin
            c = CC_NEG;
        end else if (w == '0) begin
            c = CC_ZERO;
        end else begin
            c = CC_POS;
        end
        return c;
    endfunction

    // architectural state
    logic [SizeBits-1:0] r_size;
    logic [W-1:0]        r_sp, n_sp;
    t_cc                 r_cc;
    logic [NUM_REGS-1:0] r_reg_vld;

    // stage b: register operands
    logic               r_b_valid, r_b_fresh;
    t_mode              r_b_mode;
    logic [3:0]         r_b_op, r_b_rc;
    logic               r_b_imm, r_b_idx;
    logic [RIW-1:0]     r_b_ri, r_b_r;
    logic signed [15:0] r_b_off;
    logic [PcBits-1:0]  r_b_abs, r_b_pc;
    logic [W-1:0]       r_b_immv, r_b_lval;
    logic [W-1:0]       r_b_ri_val, r_b_r_val;

    // stage c: data memory read, commit
    logic              r_c_valid;
    t_ctl              r_c_ctl, n_c_ctl;
    logic [W-1:0]      r_c_opnd, n_c_opnd, r_c_rval;
    logic [AW-1:0]     r_c_waddr, n_c_waddr;
    logic [RIW-1:0]    r_c_ridx;
    logic [PcBits-1:0] r_c_target, r_c_pc;

    // last register write, for the read issued at the same edge
    logic           r_lw_vld;
    logic [RIW-1:0] r_lw_idx;
    logic [W-1:0]   r_lw_data;

    // output register
    logic               r_o_valid;
    logic [PcBits-1:0]  r_o_npc;
    t_status            r_o_st;
    t_cc                r_o_cc;
    logic signed [31:0] r_o_reg, r_o_sp;

    logic           accept, move, commit;
    logic [W-1:0]   ri_q, r_q, dm_q;
    logic [W-1:0]   b_ri_cur, b_r_cur, b_addr, b_sp1;
    logic [PcBits-1:0] b_target;
    logic [SZW-1:0] eff_size;
    logic           addr_ok, sp_ok, sp1_ok, abs_ok;
    logic [1:0]     cond_res;
    logic [AW-1:0]  b_rd_addr;
    logic [W-1:0]   c_v, reg_wdata;
    logic           reg_we, mem_we;
    logic [PcBits-1:0] c_npc;

    assign i_in.ready = !r_b_valid;
    assign accept     = i_in.valid && !r_b_valid;
    assign move       = r_b_valid && !r_c_valid;
    assign commit     = r_c_valid && (!r_o_valid || o_res.ready);

    // register operands with forwarding
    always_comb begin
        if (r_b_fresh) begin
            if (r_lw_vld && r_lw_idx == r_b_ri) begin
                b_ri_cur = r_lw_data;
            end else begin
                b_ri_cur = r_reg_vld[r_b_ri] ? ri_q : '0;
            end
            if (r_lw_vld && r_lw_idx == r_b_r) begin
                b_r_cur = r_lw_data;
            end else begin
                b_r_cur = r_reg_vld[r_b_r] ? r_q : '0;
            end
        end else begin
            b_ri_cur = r_b_ri_val;
            b_r_cur  = r_b_r_val;
        end
    end

    assign eff_size = (SZW'(r_size) > SZW'(DATA_DEPTH)) ? SZW'(DATA_DEPTH) : SZW'(r_size);
    assign b_addr   = r_b_idx ? b_ri_cur + W'(r_b_off) : W'(r_b_abs);
    assign b_target = r_b_idx ? PcBits'(b_addr) : r_b_abs;
    assign b_sp1    = r_sp + W'(1);
    assign addr_ok  = in_data(b_addr, eff_size);
    assign sp_ok    = in_data(r_sp, eff_size);
    assign sp1_ok   = in_data(b_sp1, eff_size);
    assign abs_ok   = in_data(W'(r_b_abs), eff_size);
    assign cond_res = cond_eval(r_b_rc, r_cc);
    assign b_rd_addr = (r_b_op == OP_RET || r_b_op == OP_POP) ? b_sp1[AW-1:0]
                                                             : b_addr[AW-1:0];

    // decode and checks
    always_comb begin
        n_c_ctl   = '{st: ST_OK, wr_mem: 1'b0, wr_reg: 1'b0, use_rd: 1'b0,
                      alu: ALU_PASS, sp_op: SP_KEEP, npc_sel: NPC_PC};
        n_c_opnd  = r_b_immv;
        n_c_waddr = b_addr[AW-1:0];
        unique case (r_b_mode)
            MD_PRELOAD: begin
                if (!abs_ok) begin
                    n_c_ctl.st = ST_DATA;
                end else begin
                    n_c_ctl.wr_mem = 1'b1;
                    n_c_opnd       = r_b_lval;
                    n_c_waddr      = r_b_abs[AW-1:0];
                end
            end
            MD_SETSP: begin
                n_c_ctl.sp_op = SP_LOAD;
                n_c_opnd      = r_b_lval;
            end
            MD_RSVD: n_c_ctl.st = ST_UNK;
            MD_EXEC: begin
                unique case (r_b_op) inside
                    OP_ILL: n_c_ctl.st = ST_ILL;
                    OP_NOP: ;
                    OP_LOAD, OP_ADD, OP_SUB: begin
                        if (!r_b_imm && !addr_ok) begin
                            n_c_ctl.st = ST_DATA;
                        end else begin
                            n_c_ctl.wr_reg = 1'b1;
                            n_c_ctl.use_rd = !r_b_imm;
                            n_c_ctl.alu    = (r_b_op == OP_ADD) ? ALU_ADD :
                                             (r_b_op == OP_SUB) ? ALU_SUB : ALU_PASS;
                        end
                    end
                    OP_STORE: begin
                        if (r_b_imm) begin
                            n_c_ctl.st = ST_IMM;
                        end else if (!addr_ok) begin
                            n_c_ctl.st = ST_DATA;
                        end else begin
                            n_c_ctl.wr_mem = 1'b1;
                            n_c_opnd       = b_r_cur;
                        end
                    end
                    OP_BRANCH, OP_CALL: begin
                        if (r_b_imm) begin
                            n_c_ctl.st = ST_IMM;
                        end else if (cond_res[1]) begin
                            n_c_ctl.st = ST_COND;
                        end else if (cond_res[0]) begin
                            if (r_b_op == OP_CALL) begin
                                if (!sp_ok) begin
                                    n_c_ctl.st = ST_STACK;
                                end else begin
                                    n_c_ctl.wr_mem  = 1'b1;
                                    n_c_opnd        = W'(r_b_pc);
                                    n_c_waddr       = r_sp[AW-1:0];
                                    n_c_ctl.sp_op   = SP_DEC;
                                    n_c_ctl.npc_sel = NPC_TARGET;
                                end
                            end else begin
                                n_c_ctl.npc_sel = NPC_TARGET;
                            end
                        end
                    end
                    OP_RET: begin
                        if (!sp1_ok) begin
                            n_c_ctl.st = ST_STACK;
                        end else begin
                            n_c_ctl.sp_op   = SP_INC;
                            n_c_ctl.npc_sel = NPC_RDATA;
                        end
                    end
                    OP_PUSH: begin
                        if (!sp_ok) begin
                            n_c_ctl.st = ST_STACK;
                        end else if (!r_b_imm && !addr_ok) begin
                            n_c_ctl.st = ST_DATA;
                        end else begin
                            n_c_ctl.wr_mem = 1'b1;
                            n_c_ctl.use_rd = !r_b_imm;
                            n_c_waddr      = r_sp[AW-1:0];
                            n_c_ctl.sp_op  = SP_DEC;
                        end
                    end
                    OP_POP: begin
                        if (r_b_imm) begin
                            n_c_ctl.st = ST_IMM;
                        end else if (!sp1_ok) begin
                            n_c_ctl.st = ST_STACK;
                        end else if (!addr_ok) begin
                            n_c_ctl.st = ST_DATA;
                        end else begin
                            n_c_ctl.wr_mem = 1'b1;
                            n_c_ctl.use_rd = 1'b1;
                            n_c_ctl.sp_op  = SP_INC;
                        end
                    end
                    OP_HALT: n_c_ctl.st = ST_HALT;
                    default: n_c_ctl.st = ST_UNK;
                endcase
            end
            default: n_c_ctl.st = ST_UNK;
        endcase
    end

    // commit
    assign c_v = r_c_ctl.use_rd ? dm_q : r_c_opnd;

    always_comb begin
        case (r_c_ctl.alu)
            ALU_ADD: reg_wdata = r_c_rval + c_v;
            ALU_SUB: reg_wdata = r_c_rval - c_v;
            default: reg_wdata = c_v;
        endcase
        case (r_c_ctl.sp_op)
            SP_LOAD: n_sp = r_c_opnd;
            SP_INC:  n_sp = r_sp + W'(1);
            SP_DEC:  n_sp = r_sp - W'(1);
            default: n_sp = r_sp;
        endcase
        case (r_c_ctl.npc_sel)
            NPC_TARGET: c_npc = r_c_target;
            NPC_RDATA:  c_npc = PcBits'(dm_q);
            default:    c_npc = r_c_pc;
        endcase
    end

    assign reg_we = commit && r_c_ctl.wr_reg;
    assign mem_we = commit && r_c_ctl.wr_mem;

    rscpu_ram #(.WIDTH(W), .DEPTH(NUM_REGS)) u_reg_idx (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (r_c_ridx),
        .i_wdata (reg_wdata),
        .i_re    (accept),
        .i_raddr (reg_sel(i_in.index_reg)),
        .o_rdata (ri_q)
    );

    rscpu_ram #(.WIDTH(W), .DEPTH(NUM_REGS)) u_reg_dst (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (r_c_ridx),
        .i_wdata (reg_wdata),
        .i_re    (accept),
        .i_raddr (reg_sel(i_in.cond_or_reg)),
        .o_rdata (r_q)
    );

    rscpu_ram #(.WIDTH(W), .DEPTH(DATA_DEPTH)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_c_waddr),
        .i_wdata (c_v),
        .i_re    (move),
        .i_raddr (b_rd_addr),
        .o_rdata (dm_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SizeReset;
            r_sp      <= '0;
            r_cc      <= CC_UNSET;
            r_reg_vld <= '0;
            r_b_valid <= 1'b0;
            r_b_fresh <= 1'b0;
            r_c_valid <= 1'b0;
            r_lw_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (commit) begin
                r_sp <= n_sp;
                if (r_c_ctl.wr_reg) begin
                    r_cc <= cc_of(reg_wdata);
                end
            end
            if (reg_we) begin
                r_reg_vld[r_c_ridx] <= 1'b1;
            end
            r_lw_vld  <= reg_we;
            r_b_fresh <= accept;
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (move) begin
                r_b_valid <= 1'b0;
            end
            if (move) begin
                r_c_valid <= 1'b1;
            end else if (commit) begin
                r_c_valid <= 1'b0;
            end
            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_mode <= t_mode'(i_in.mode);
            r_b_op   <= i_in.opcode;
            r_b_rc   <= i_in.cond_or_reg;
            r_b_imm  <= i_in.immediate_flag;
            r_b_idx  <= i_in.indexed_flag;
            r_b_ri   <= reg_sel(i_in.index_reg);
            r_b_r    <= reg_sel(i_in.cond_or_reg);
            r_b_off  <= i_in.offset;
            r_b_abs  <= i_in.abs_address;
            r_b_pc   <= i_in.pc_after_fetch;
            r_b_immv <= W'(i_in.imm_value);
            r_b_lval <= W'(i_in.load_value);
        end
        r_b_ri_val <= (reg_we && r_c_ridx == r_b_ri) ? reg_wdata : b_ri_cur;
        r_b_r_val  <= (reg_we && r_c_ridx == r_b_r) ? reg_wdata : b_r_cur;
        r_lw_idx   <= r_c_ridx;
        r_lw_data  <= reg_wdata;
        if (move) begin
            r_c_ctl    <= n_c_ctl;
            r_c_opnd   <= n_c_opnd;
            r_c_waddr  <= n_c_waddr;
            r_c_rval   <= b_r_cur;
            r_c_ridx   <= r_b_r;
            r_c_target <= b_target;
            r_c_pc     <= r_b_pc;
        end
        if (commit) begin
            r_o_npc <= c_npc;
            r_o_st  <= r_c_ctl.st;
            r_o_cc  <= r_c_ctl.wr_reg ? cc_of(reg_wdata) : r_cc;
            r_o_reg <= 32'(signed'(r_c_ctl.wr_reg ? reg_wdata : r_c_rval));
            r_o_sp  <= 32'(signed'(n_sp));
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.next_pc       = r_o_npc;
    assign o_res.status        = r_o_st;
    assign o_res.cond_code     = r_o_cc;
    assign o_res.reg_value     = r_o_reg;
    assign o_res.stack_pointer = r_o_sp;

    // a result waiting in the output register holds back every commit; checked on sp and cc
    a_stall_holds_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_o_valid && !o_res.ready) |=> $stable(r_sp) && $stable(r_cc))
        else $error("state changed while result stalled");

    // an error result never comes with a state change
    a_err_no_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_o_valid) && r_o_st != ST_OK) |-> $stable(r_sp) && $stable(r_cc))
        else $error("state changed on error result");

    // forwarding entry only follows a register write
    a_lw_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lw_vld |-> $past(r_c_valid && r_c_ctl.wr_reg))
        else $error("forwarding entry without register write");

    // a data read is never issued under a pending commit
    a_read_no_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |-> !commit)
        else $error("data read overlaps commit");
endmodule
